>>> src/dpbt_pkg.sv
// Shared constants, codes and controller/datapath types for the dirty page tracker.
package dpbt_pkg;

  localparam int OP_W       = 2;
  localparam int OFFSET_W   = 22;
  localparam int PAGE_OUT_W = 10;
  localparam int COUNT_W    = 11;
  localparam int ARENA_W    = 11;

  localparam logic [ARENA_W-1:0] ARENA_RESET = 11'd1024;

  localparam int NUM_PAGES_DEF  = 1024;
  localparam int PAGE_SHIFT_DEF = 12;
  localparam int WORD_BITS_DEF  = 64;

  typedef enum logic [OP_W-1:0] {
    OP_MARK  = 2'd0,
    OP_TAKE  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic load;    // capture the accepted word
    logic lookup;  // pick bitmap word, read it
    logic commit;  // update state, load result register
  } cmd_t;

  typedef struct packed {
    logic out_free;  // result register can take a new word this cycle
  } status_t;

endpackage

>>> src/dpbt_if.sv
// Valid/ready channel interfaces: input items, results, arena size writes.
interface dpbt_in_if;
  logic                          valid;
  logic                          ready;
  logic [dpbt_pkg::OP_W-1:0]     operation;
  logic [dpbt_pkg::OFFSET_W-1:0] byte_offset;

  modport source (output valid, output operation, output byte_offset, input ready);
  modport sink   (input valid, input operation, input byte_offset, output ready);
endinterface

interface dpbt_out_if;
  logic                            valid;
  logic                            ready;
  logic [dpbt_pkg::PAGE_OUT_W-1:0] page_number;
  logic [dpbt_pkg::COUNT_W-1:0]    dirty_count;
  logic                            newly_dirty;
  logic                            empty_res;
  logic                            out_of_range;

  modport source (output valid, output page_number, output dirty_count, output newly_dirty,
                  output empty_res, output out_of_range, input ready);
  modport sink   (input valid, input page_number, input dirty_count, input newly_dirty,
                  input empty_res, input out_of_range, output ready);
endinterface

interface dpbt_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [dpbt_pkg::ARENA_W-1:0] arena_pages;

  modport source (output valid, output arena_pages, input ready);
  modport sink   (input valid, input arena_pages, output ready);
endinterface

>>> src/dirty_page_bitmap_tracker_core.sv
// Top level of the dirty page bitmap tracker: channel wiring, controller and datapath.
//
// Usage:
//   in_if   carries one word per item: operation (mark, take next, clear) and byte_offset.
//   out_if  returns exactly one result word per item, in order: page_number, dirty_count,
//           newly_dirty, empty_res, out_of_range.
//   cfg_if  writes arena_pages; always ready. Write it only while the block is idle.
// Timing:
//   An item is accepted in the idle state, its bitmap word is chosen and read in the
//   read state (lowest word from the per-word nonzero summary for take, the page's word
//   for mark), and state is updated and the result registered in the exec state. Only
//   one item is in flight at a time, so a new item is taken only after the last one has
//   committed; the next item may be accepted while a result waits.
// Stall:
//   If the receiver holds out_if.ready low, the following item waits in its commit
//   cycle until the output register frees; nothing is dropped or repeated.
// Reset:
//   rst_n (synchronous, active low) clears the summary bits and the count and sets
//   arena_pages to 1024. The memory is not swept: a word whose summary bit is clear
//   reads as zero, so reset and clear both take effect at once.
module dirty_page_bitmap_tracker_core #(
  parameter int NUM_PAGES  = dpbt_pkg::NUM_PAGES_DEF,
  parameter int PAGE_SHIFT = dpbt_pkg::PAGE_SHIFT_DEF,
  parameter int WORD_BITS  = dpbt_pkg::WORD_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  dpbt_in_if.sink    in_if,
  dpbt_out_if.source out_if,
  dpbt_cfg_if.sink   cfg_if
);
  import dpbt_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  assign in_if.ready  = in_ready;
  assign cfg_if.ready = 1'b1;

  dpbt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  dpbt_datapath #(
    .NUM_PAGES  (NUM_PAGES),
    .PAGE_SHIFT (PAGE_SHIFT),
    .WORD_BITS  (WORD_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_operation     (in_if.operation),
    .in_byte_offset   (in_if.byte_offset),
    .cfg_we           (cfg_if.valid),
    .cfg_arena_pages  (cfg_if.arena_pages),
    .out_valid        (out_if.valid),
    .out_ready        (out_if.ready),
    .out_page_number  (out_if.page_number),
    .out_dirty_count  (out_if.dirty_count),
    .out_newly_dirty  (out_if.newly_dirty),
    .out_empty_res    (out_if.empty_res),
    .out_out_of_range (out_if.out_of_range)
  );

endmodule

>>> src/dpbt_ctrl.sv
// Controller: sequences accept, bitmap word lookup and commit for one word at a time.
module dpbt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  dpbt_pkg::status_t status,
  output dpbt_pkg::cmd_t    cmd
);
  import dpbt_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.lookup = 1'b0;
    cmd.commit = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        cmd.lookup = 1'b1;
        state_nxt  = ST_EXEC;
      end
      ST_EXEC: begin
        // wait here while the result register is still held by the receiver
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

>>> src/dpbt_datapath.sv
// Datapath: bitmap memory, nonzero summary, dirty count, arena register, result register.
module dpbt_datapath #(
  parameter int NUM_PAGES  = dpbt_pkg::NUM_PAGES_DEF,
  parameter int PAGE_SHIFT = dpbt_pkg::PAGE_SHIFT_DEF,
  parameter int WORD_BITS  = dpbt_pkg::WORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  dpbt_pkg::cmd_t                  cmd,
  output dpbt_pkg::status_t               status,
  input  logic [dpbt_pkg::OP_W-1:0]       in_operation,
  input  logic [dpbt_pkg::OFFSET_W-1:0]   in_byte_offset,
  input  logic                            cfg_we,
  input  logic [dpbt_pkg::ARENA_W-1:0]    cfg_arena_pages,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [dpbt_pkg::PAGE_OUT_W-1:0] out_page_number,
  output logic [dpbt_pkg::COUNT_W-1:0]    out_dirty_count,
  output logic                            out_newly_dirty,
  output logic                            out_empty_res,
  output logic                            out_out_of_range
);
  import dpbt_pkg::*;

  localparam int NUM_WORDS = NUM_PAGES / WORD_BITS;
  localparam int BI        = $clog2(WORD_BITS);
  localparam int WI        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int PW        = OFFSET_W - PAGE_SHIFT;
  localparam int PXW       = PW + WI + BI;
  localparam int CW        = (PW > ARENA_W) ? PW : ARENA_W;

  // arena size and tracked state
  logic [ARENA_W-1:0]   arena_r;
  logic [NUM_WORDS-1:0] summary_r, summary_nxt;
  logic [COUNT_W-1:0]   count_r, count_nxt;
  logic [WORD_BITS-1:0] bitmap_mem [NUM_WORDS];

  // captured item
  logic [OP_W-1:0] op_r;
  logic [PW-1:0]   page_r;
  logic            oor_r;

  // lookup results
  logic [WORD_BITS-1:0] rdata_r;
  logic [WI-1:0]        addr_r;
  logic                 wvalid_r;
  logic                 found_r;

  // result register
  logic                  out_valid_r;
  logic [PAGE_OUT_W-1:0] page_out_r, page_out_nxt;
  logic                  newly_r, newly_nxt;
  logic                  empty_r, empty_nxt;
  logic                  oor_out_r, oor_out_nxt;

  logic [PW-1:0]        in_page;
  logic                 in_oor;
  logic [PXW-1:0]       page_x;
  logic [WI-1:0]        mark_word;
  logic [BI-1:0]        mark_bit;
  logic [WI-1:0]        take_word;
  logic [WI-1:0]        lookup_addr;
  logic [WORD_BITS-1:0] cur_word;
  logic [BI-1:0]        low_bit;
  logic [WORD_BITS-1:0] new_word;
  logic                 mem_we;

  // page of the incoming offset and its range check
  assign in_page = in_byte_offset[OFFSET_W-1:PAGE_SHIFT];
  assign in_oor  = (CW'(in_page) >= CW'(arena_r)) || (32'(in_page) >= 32'(NUM_PAGES));

  assign page_x    = PXW'(page_r);
  assign mark_word = page_x[BI +: WI];
  assign mark_bit  = page_x[BI-1:0];

  // lowest word with any dirty bit
  always_comb begin
    take_word = '0;
    for (int i = NUM_WORDS - 1; i >= 0; i--) begin
      if (summary_r[i]) take_word = WI'(i);
    end
  end

  assign lookup_addr = (op_r == OP_TAKE) ? take_word : mark_word;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_operation;
      page_r <= in_page;
      oor_r  <= in_oor;
    end
    if (cmd.lookup) begin
      addr_r   <= lookup_addr;
      wvalid_r <= summary_r[lookup_addr];
      found_r  <= |summary_r;
    end
  end

  // bitmap memory: one read port, one write port
  always_ff @(posedge clk) begin
    if (cmd.lookup) rdata_r <= bitmap_mem[lookup_addr];
    if (mem_we) bitmap_mem[addr_r] <= new_word;
  end

  // a word with a clear summary bit is all zero, whatever the memory holds
  assign cur_word = wvalid_r ? rdata_r : '0;

  always_comb begin
    low_bit = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (cur_word[i]) low_bit = BI'(i);
    end
  end

  always_comb begin
    summary_nxt  = summary_r;
    count_nxt    = count_r;
    new_word     = cur_word;
    mem_we       = 1'b0;
    page_out_nxt = '0;
    newly_nxt    = 1'b0;
    empty_nxt    = 1'b0;
    oor_out_nxt  = 1'b0;
    case (op_r)
      OP_MARK: begin
        if (oor_r) begin
          oor_out_nxt = 1'b1;
        end else begin
          newly_nxt            = ~cur_word[mark_bit];
          new_word             = cur_word | (WORD_BITS'(1) << mark_bit);
          mem_we               = cmd.commit;
          summary_nxt[addr_r]  = 1'b1;
          page_out_nxt         = PAGE_OUT_W'(page_r);
          if (newly_nxt) count_nxt = count_r + COUNT_W'(1);
        end
      end
      OP_TAKE: begin
        if (found_r) begin
          new_word            = cur_word & ~(WORD_BITS'(1) << low_bit);
          mem_we              = cmd.commit;
          summary_nxt[addr_r] = |new_word;
          page_out_nxt        = PAGE_OUT_W'({addr_r, low_bit});
          if (count_r != '0) count_nxt = count_r - COUNT_W'(1);
        end else begin
          empty_nxt = 1'b1;
        end
      end
      OP_CLEAR: begin
        summary_nxt = '0;
        count_nxt   = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arena_r     <= ARENA_RESET;
      summary_r   <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) arena_r <= cfg_arena_pages;
      if (cmd.commit) begin
        summary_r   <= summary_nxt;
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      page_out_r <= page_out_nxt;
      newly_r    <= newly_nxt;
      empty_r    <= empty_nxt;
      oor_out_r  <= oor_out_nxt;
    end
  end

  assign status.out_free  = ~out_valid_r | out_ready;
  assign out_valid        = out_valid_r;
  assign out_page_number  = page_out_r;
  assign out_dirty_count  = count_r;
  assign out_newly_dirty  = newly_r;
  assign out_empty_res    = empty_r;
  assign out_out_of_range = oor_out_r;

  a_commit_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("commit did not present a result");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && (op_r == OP_CLEAR) |=> (summary_r == '0) && (count_r == '0))
    else $error("clear left dirty state behind");

  a_mark_sets_summary: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && (op_r == OP_MARK) && !oor_r |=> summary_r[$past(addr_r)])
    else $error("accepted mark left its word flagged clean");

endmodule

>>> tb/tb.sv
// Testbench for the dirty page bitmap tracker: directed and random items checked against a predictor.
module tb;
  import dpbt_pkg::*;

  localparam int PAGES       = NUM_PAGES_DEF;
  localparam int WORD        = WORD_BITS_DEF;
  localparam int NUM_WORDS   = PAGES / WORD;
  localparam int SHIFT       = PAGE_SHIFT_DEF;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 200000;

  // operation code 3 is not defined; the block must leave its state alone
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [PAGE_OUT_W-1:0] page;
    logic [COUNT_W-1:0]    count;
    logic                  newly;
    logic                  empty;
    logic                  oor;
  } dirty_result_t;

  logic clk = 1'b0;
  logic rst_n;

  dpbt_in_if  in_ch ();
  dpbt_out_if out_ch ();
  dpbt_cfg_if cfg_ch ();

  dirty_page_bitmap_tracker_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the tracker state
  logic [WORD-1:0]    shadow_words [NUM_WORDS];
  logic [COUNT_W-1:0] shadow_total;
  logic [ARENA_W-1:0] shadow_arena;

  dirty_result_t pending_results [$];

  int send_idle_pct;
  int recv_idle_pct;
  bit hold_request;
  int hold_left;
  int mismatch_count;
  int words_sent;
  int results_checked;
  int arena_writes;
  int newly_seen;
  int empty_seen;
  int oor_seen;
  int cycle_count;

  function automatic dirty_result_t predict_dirty_result(input logic [OP_W-1:0] op,
                                                         input logic [OFFSET_W-1:0] offset);
    dirty_result_t r;
    int unsigned   pg;
    int unsigned   lim;
    bit            found;
    r = '0;
    found = 1'b0;
    case (op)
      OP_MARK: begin
        pg  = offset >> SHIFT;
        lim = (shadow_arena > PAGES) ? PAGES : shadow_arena;
        if (pg >= lim) begin
          r.oor = 1'b1;
        end else begin
          if (!shadow_words[pg / WORD][pg % WORD]) begin
            shadow_words[pg / WORD][pg % WORD] = 1'b1;
            shadow_total = shadow_total + 1'b1;
            r.newly = 1'b1;
          end
          r.page = pg[PAGE_OUT_W-1:0];
        end
      end
      OP_TAKE: begin
        // lowest dirty page over the whole bitmap, even above a shrunk arena
        for (int w = 0; w < NUM_WORDS; w++) begin
          for (int b = 0; b < WORD; b++) begin
            if (!found && shadow_words[w][b]) begin
              found = 1'b1;
              shadow_words[w][b] = 1'b0;
              if (shadow_total != 0) shadow_total = shadow_total - 1'b1;
              r.page = PAGE_OUT_W'(w * WORD + b);
            end
          end
        end
        r.empty = !found;
      end
      OP_CLEAR: begin
        for (int w = 0; w < NUM_WORDS; w++) shadow_words[w] = '0;
        shadow_total = '0;
      end
      default: ;
    endcase
    r.count = shadow_total;
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // predictor and scoreboard: input words first so a same-edge result still finds its entry
  always @(posedge clk) begin : result_check
    dirty_result_t want;
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        shadow_arena = cfg_ch.arena_pages;
        arena_writes++;
      end
      if (in_ch.valid && in_ch.ready) begin
        pending_results.push_back(predict_dirty_result(in_ch.operation, in_ch.byte_offset));
        words_sent++;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result word with nothing expected, page %0d count %0d", $time,
                   out_ch.page_number, out_ch.dirty_count);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("page_number", want.page, out_ch.page_number);
          check_field("dirty_count", want.count, out_ch.dirty_count);
          check_field("newly_dirty", want.newly, out_ch.newly_dirty);
          check_field("empty_res", want.empty, out_ch.empty_res);
          check_field("out_of_range", want.oor, out_ch.out_of_range);
          results_checked++;
          newly_seen += want.newly;
          empty_seen += want.empty;
          oor_seen   += want.oor;
        end
      end
    end
  end

  // result receiver: random stalls, or one long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left    <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else if (hold_request) begin
        hold_left    <= HOLD_CYCLES;
        hold_request <= 1'b0;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // one word on the input channel; valid stays high on return
  task automatic send_word(input logic [OP_W-1:0] op, input logic [OFFSET_W-1:0] offset);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.operation   <= op;
    in_ch.byte_offset <= offset;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic stop_sending();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_results();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_arena(input logic [ARENA_W-1:0] pages);
    drain_results();
    repeat (3) @(posedge clk);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.arena_pages <= pages;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [OFFSET_W-1:0] offset_of_page(input int unsigned pg);
    return {pg[PAGE_OUT_W-1:0], SHIFT'($urandom)};
  endfunction

  // page for a mark: mostly a small hot set spread over words, so repeats and takes interact
  function automatic int unsigned pick_page();
    int unsigned sel;
    int          lim;
    int          pg;
    sel = $urandom_range(0, 99);
    lim = (shadow_arena > PAGES) ? PAGES : shadow_arena;
    if (sel < 55) begin
      pg = $urandom_range(0, NUM_WORDS - 1) * WORD + $urandom_range(0, 3) * 21;
    end else if (sel < 80) begin
      pg = $urandom_range(0, PAGES - 1);
    end else begin
      pg = lim + $urandom_range(0, 2) - 1;
    end
    if (pg < 0) pg = 0;
    if (pg > PAGES - 1) pg = PAGES - 1;
    return pg;
  endfunction

  task automatic test_directed_ops();
    send_word(OP_TAKE, '0);              // take on empty bitmap
    send_word(OP_MARK, 22'h000000);      // page 0, new
    send_word(OP_MARK, 22'h000FFF);      // page 0 again
    send_word(OP_MARK, 22'h3FFFFF);      // top page
    send_word(OP_MARK, 22'h001000);      // page 1
    send_word(OP_MARK, 22'h2AAAAA);
    send_word(OP_TAKE, 22'h155555);      // offset ignored by take
    send_word(OP_TAKE, '0);
    send_word(OP_UNUSED, 22'h3FFFFF);
    send_word(OP_CLEAR, 22'h155555);
    send_word(OP_TAKE, '0);
    send_word(OP_MARK, 22'h040000);      // first page of word 1
    send_word(OP_TAKE, '0);
    stop_sending();
  endtask

  task automatic test_arena_edges();
    write_arena(11'd1);
    send_word(OP_MARK, 22'h000FFF);      // last byte of the only page
    send_word(OP_MARK, 22'h001000);      // rejected
    send_word(OP_TAKE, '0);
    stop_sending();
    write_arena(11'd0);                  // every mark rejected
    send_word(OP_MARK, 22'h000000);
    stop_sending();
    write_arena(11'h7FF);                // above capacity acts as full size
    send_word(OP_MARK, 22'h3FFFFF);
    send_word(OP_MARK, 22'h03F123);
    stop_sending();
    write_arena(11'd64);                 // shrink below dirty page 1023
    send_word(OP_MARK, 22'h03FFFF);      // repeat of page 63
    send_word(OP_MARK, 22'h040000);      // rejected
    send_word(OP_TAKE, '0);
    send_word(OP_TAKE, '0);              // page 1023 still comes out
    send_word(OP_TAKE, '0);
    stop_sending();
  endtask

  // bursts of marks drained by takes, with stray single words mixed in
  task automatic run_random_mix(input int n_items);
    int sent;
    int sel;
    int k;
    int t;
    sent = 0;
    while (sent < n_items) begin
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
        k = $urandom_range(1, 12);
        t = $urandom_range(1, k + 2);
        for (int i = 0; i < k; i++) send_word(OP_MARK, offset_of_page(pick_page()));
        for (int i = 0; i < t; i++) send_word(OP_TAKE, OFFSET_W'($urandom));
        sent += k + t;
      end else begin
        if (sel < 70)      send_word(OP_MARK, OFFSET_W'($urandom));
        else if (sel < 80) send_word(OP_MARK, offset_of_page(pick_page()));
        else if (sel < 88) send_word(OP_TAKE, OFFSET_W'($urandom));
        else if (sel < 94) send_word(OP_CLEAR, OFFSET_W'($urandom));
        else               send_word(OP_UNUSED, OFFSET_W'($urandom));
        sent++;
      end
    end
    stop_sending();
  endtask

  task automatic test_random_phases();
    send_idle_pct = 31;
    recv_idle_pct = 71;
    write_arena(11'd1024);
    run_random_mix(250);
    send_idle_pct = 71;
    recv_idle_pct = 31;
    write_arena(11'd300);
    run_random_mix(220);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_arena(11'h7FF);
    run_random_mix(200);
  endtask

  // receiver holds off for a long stretch while words keep coming
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_arena(11'd1024);
    hold_request <= 1'b1;
    run_random_mix(40);
    drain_results();
  endtask

  initial begin
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.operation    <= OP_MARK;
    in_ch.byte_offset  <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.arena_pages <= ARENA_RESET;
    hold_request       <= 1'b0;
    hold_left          = 0;
    send_idle_pct      = 31;
    recv_idle_pct      = 71;
    mismatch_count     = 0;
    words_sent         = 0;
    results_checked    = 0;
    arena_writes       = 0;
    newly_seen         = 0;
    empty_seen         = 0;
    oor_seen           = 0;
    cycle_count        = 0;
    for (int w = 0; w < NUM_WORDS; w++) shadow_words[w] = '0;
    shadow_total = '0;
    shadow_arena = ARENA_RESET;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_ops();
    test_arena_edges();
    test_random_phases();
    test_output_backpressure();

    drain_results();
    repeat (8) @(posedge clk);

    $display("covered %0d input words over %0d arena writes, three idle mixes, one long stall",
             words_sent, arena_writes);
    $display("checked %0d results: %0d new marks, %0d empty takes, %0d rejected marks",
             results_checked, newly_seen, empty_seen, oor_seen);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
